/* hw/rtl/mpsnr_pkg.sv */
`default_nettype none
package mpsnr_pkg;

	// Fixed constants of the dB conversion.
	localparam logic [17:0] K_Q16   = 18'd197283;

	// Controller states.
	typedef enum logic [5:0] {
		ST_ACC  = 6'b000001,
		ST_LOGW = 6'b000010,
		ST_LOGE = 6'b000100,
		ST_LOGR = 6'b001000,
		ST_COMB = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	// Log unit operand select.
	typedef enum logic [1:0] {
		LSEL_W = 2'b00,
		LSEL_E = 2'b01,
		LSEL_R = 2'b10
	} lsel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  acc_en;
		logic  clr;
		logic  log_start;
		lsel_t log_sel;
		logic  log_save;
		logic  comb_en;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic log_done;
		logic last_s1;
	} sts_t;

	// Register indexes.
	localparam logic [1:0] REG_RANGE = 2'd0;
	localparam logic [1:0] REG_MASK  = 2'd1;
	localparam logic [1:0] REG_BYTE  = 2'd2;

endpackage
`default_nettype wire

/* hw/rtl/mpsnr_log2.sv */
`default_nettype none
// Iterative log2 in Q16: leading-one search over one cycle per bit,
// then one squaring per fraction bit.
module mpsnr_log2 import mpsnr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] x,
	output logic             done,
	output logic [22:0]      result
);
	logic [63:0] t_q;
	logic [5:0]  n_q;
	logic [32:0] y_q;
	logic [15:0] frac_q;
	logic [4:0]  cnt_q;
	logic [1:0]  ph_q;
	logic [65:0] sq;
	logic [33:0] ys;
	logic [63:0] yn;

	// Square of the Q1.31 mantissa, back to Q1.31.
	assign sq = 66'(y_q) * 66'(y_q);
	assign ys = 34'(sq >> 31);
	assign yn = x << (6'd63 - n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
			t_q <= '0;
			n_q <= '0;
			y_q <= '0;
			frac_q <= '0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (ph_q)
				2'd0: begin
					if (start) begin
						t_q <= x;
						n_q <= '0;
						ph_q <= 2'd1;
					end
				end
				// Leading-one search, one bit per cycle.
				2'd1: begin
					if (t_q > 64'd1) begin
						t_q <= t_q >> 1;
						n_q <= n_q + 6'd1;
					end else begin
						y_q <= {1'b0, yn[63:32]};
						frac_q <= '0;
						cnt_q <= '0;
						ph_q <= 2'd2;
					end
				end
				// One fraction bit per squaring.
				2'd2: begin
					if (ys[32]) begin
						y_q <= ys[33:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						y_q <= ys[32:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						ph_q <= 2'd0;
						done <= 1'b1;
					end
				end
				default: ph_q <= 2'd0;
			endcase
		end
	end

	assign result = {1'b0, n_q, frac_q};
endmodule
`default_nettype wire

/* hw/rtl/mpsnr_datapath.sv */
`default_nettype none
// Sample accumulation, log unit and dB combination.
module mpsnr_datapath import mpsnr_pkg::*; #(
	parameter int MAX_SAMPLES_LOG2 = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [15:0] data_range,
	input  wire logic        use_mask,
	input  wire logic        target_is_byte,
	input  wire logic [15:0] pred_sample,
	input  wire logic [15:0] target_sample,
	input  wire logic [7:0]  mask_weight,
	input  wire logic        last_sample,
	output logic [15:0]      psnr_db,
	output logic             status
);
	localparam int          ERR_W   = 38 + MAX_SAMPLES_LOG2;
	localparam int          ERR_WC  = (ERR_W > 64) ? 64 : ERR_W;
	localparam logic [63:0] ERR_MAX = {64{1'b1}} >> (64 - ERR_WC);

	logic [63:0] err_q;
	logic [31:0] wsum_q;
	logic [31:0] sq_s1;
	logic [7:0]  w_s1;
	logic        v_s1, last_s1;
	logic [22:0] lw_q, le_q, lr_q;
	logic        log_done;
	logic [22:0] log_res;
	logic [63:0] log_x;
	logic [16:0] targ;
	logic [17:0] diff;
	logic [16:0] adiff;
	logic [14:0] blo;
	logic [30:0] bq;
	logic [15:0] bscale;
	logic [40:0] contrib;
	logic [64:0] esum;
	logic [32:0] wsn;
	logic signed [47:0] a_s, b_s;
	logic signed [48:0] tot;
	logic [48:0] mag, rnd;
	logic [24:0] r;

	// Byte target scaled to Q1.15 with rounding: b*128 plus (b*128+127)/255,
	// the quotient taken by reciprocal multiplication, exact below 2^15.
	assign blo = {target_sample[7:0], 7'h7F};
	assign bq = 31'(blo) * 31'd32897;
	assign bscale = {1'b0, target_sample[7:0], 7'd0} + 16'(bq[30:23]);
	assign targ = target_is_byte ? {1'b0, bscale} : {1'b0, target_sample};
	assign diff = {2'b0, pred_sample} - {1'b0, targ};
	assign adiff = diff[17] ? 17'(-diff) : diff[16:0];

	// Stage 1: square and weight select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.acc_en;
			if (cmd.acc_en) last_s1 <= last_sample;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			sq_s1 <= 32'(34'(adiff) * 34'(adiff));
			w_s1 <= use_mask ? mask_weight : 8'd1;
		end
	end

	assign contrib = 41'(sq_s1) * 41'(w_s1);
	assign esum = 65'(err_q) + 65'(contrib);
	assign wsn = 33'(wsum_q) + 33'(w_s1);

	// Saturating sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
			wsum_q <= '0;
		end else if (cmd.clr) begin
			err_q <= '0;
			wsum_q <= '0;
		end else if (v_s1) begin
			err_q <= (esum > 65'(ERR_MAX)) ? ERR_MAX : esum[63:0];
			wsum_q <= wsn[32] ? 32'hFFFF_FFFF : wsn[31:0];
		end
	end

	always_comb begin
		case (cmd.log_sel)
			LSEL_W:  log_x = 64'(wsum_q);
			LSEL_E:  log_x = err_q;
			default: log_x = 64'(data_range);
		endcase
	end

	mpsnr_log2 u_log (
		.clk(clk), .arst_n(arst_n), .start(cmd.log_start), .x(log_x),
		.done(log_done), .result(log_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.log_save) begin
			case (cmd.log_sel)
				LSEL_W:  lw_q <= log_res;
				LSEL_E:  le_q <= log_res;
				default: lr_q <= log_res;
			endcase
		end
	end

	// dB terms in Q32.
	always_comb begin
		a_s = 48'(signed'({25'd0, lw_q})) + (48'sd30 <<< 16)
			- 48'(signed'({25'd0, le_q}));
		a_s = 48'(a_s * signed'({30'd0, K_Q16}));
		if (err_q == 64'd0 || a_s > (48'sd100 <<< 32)) a_s = 48'sd100 <<< 32;
		b_s = 48'(signed'({25'd0, lr_q})) - (48'sd8 <<< 16);
		b_s = 48'(b_s * signed'({29'd0, K_Q16, 1'b0}));
		tot = 49'(a_s) + 49'(b_s);
		mag = tot[48] ? 49'(-tot) : tot;
		rnd = mag + (49'd1 << 23);
		r = rnd[48:24];
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.comb_en) begin
			if (wsum_q == 32'd0) begin
				psnr_db <= 16'd0;
				status <= 1'b1;
			end else if (data_range == 16'd0) begin
				psnr_db <= 16'h8000;
				status <= 1'b0;
			end else if (!tot[48]) begin
				psnr_db <= (r > 25'd32767) ? 16'h7FFF : r[15:0];
				status <= 1'b0;
			end else begin
				psnr_db <= (r > 25'd32768) ? 16'h8000 : 16'(-r[15:0]);
				status <= 1'b0;
			end
		end
	end

	assign sts.log_done = log_done;
	assign sts.last_s1 = v_s1 & last_s1;
endmodule
`default_nettype wire

/* hw/rtl/mpsnr_ctrl.sv */
`default_nettype none
// Sequencer: accumulate, then three logs, combine and hold the result.
module mpsnr_ctrl import mpsnr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t st_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_ACC;
			busy_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_ACC: begin
					if (sts.last_s1) st_q <= ST_LOGW;
				end
				ST_LOGW: begin
					busy_q <= 1'b1;
					if (sts.log_done) begin st_q <= ST_LOGE; busy_q <= 1'b0; end
				end
				ST_LOGE: begin
					busy_q <= 1'b1;
					if (sts.log_done) begin st_q <= ST_LOGR; busy_q <= 1'b0; end
				end
				ST_LOGR: begin
					busy_q <= 1'b1;
					if (sts.log_done) begin st_q <= ST_COMB; busy_q <= 1'b0; end
				end
				ST_COMB: st_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) st_q <= ST_ACC;
				end
				default: st_q <= ST_ACC;
			endcase
		end
	end

	// A last sample blocks intake until the result has been taken.
	assign in_ready = (st_q == ST_ACC) && !sts.last_s1;
	assign out_valid = (st_q == ST_OUT);

	always_comb begin
		cmd.acc_en = in_valid && in_ready;
		cmd.log_start = !busy_q &&
			(st_q == ST_LOGW || st_q == ST_LOGE || st_q == ST_LOGR);
		cmd.log_sel = (st_q == ST_LOGE) ? LSEL_E : (st_q == ST_LOGR) ? LSEL_R : LSEL_W;
		cmd.log_save = sts.log_done;
		cmd.comb_en = (st_q == ST_COMB);
		cmd.clr = (st_q == ST_COMB);
	end

	// The result is held until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("intake during output");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
endmodule
`default_nettype wire

/* hw/rtl/masked_psnr_accumulator_core.sv */
`default_nettype none
// Channel   | Handshake          | Payload
// in        | in_valid/in_ready  | pred_sample, target_sample, mask_weight, last_sample
// out       | out_valid/out_ready| psnr_db, status
// cfg       | cfg_we             | cfg_index, cfg_data
// One sample per cycle is taken while an image streams in.
// A last sample then leads to three logs in the shared log unit, each a leading-one
// search and then the squarings, and a combine step before the result is offered, where the search runs
// one cycle per bit up to and including the operand's leading one.
// Intake stops from the last sample until the result transfer completes.
// Reset clears the sums and loads data_range 1.0, masking and byte mode off.
module masked_psnr_accumulator_core import mpsnr_pkg::*; #(
	parameter int MAX_SAMPLES_LOG2 = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] pred_sample,
	input  wire logic [15:0] target_sample,
	input  wire logic [7:0]  mask_weight,
	input  wire logic        last_sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      psnr_db,
	output logic             status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	logic [15:0] range_q;
	logic        mask_q, byte_q;
	cmd_t        cmd;
	sts_t        sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= 16'd256;
			mask_q <= 1'b0;
			byte_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE: range_q <= cfg_data;
				REG_MASK:  mask_q <= cfg_data[0];
				REG_BYTE:  byte_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mpsnr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	mpsnr_datapath #(.MAX_SAMPLES_LOG2(MAX_SAMPLES_LOG2)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.data_range(range_q), .use_mask(mask_q), .target_is_byte(byte_q),
		.pred_sample(pred_sample), .target_sample(target_sample),
		.mask_weight(mask_weight), .last_sample(last_sample),
		.psnr_db(psnr_db), .status(status)
	);
endmodule
`default_nettype wire

/* tb/masked_psnr_accumulator_core_tb.sv */
`timescale 1ns / 1ps
module masked_psnr_accumulator_core_tb import mpsnr_pkg::*;;

	localparam int MAX_LOG2 = 24;
	localparam logic [63:0] ERR_CAP = 64'hFFFF_FFFF_FFFF_FFFF >> (26 - MAX_LOG2);
	localparam longint K_DB = 197283;
	localparam longint DB_CAP = longint'(100) <<< 32;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 400;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [15:0] psnr;
		logic        empty;
	} psnr_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] pred_sample;
	logic [15:0] target_sample;
	logic [7:0]  mask_weight;
	logic        last_sample;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] psnr_db;
	logic        status;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Predictor copy of the registers and the running sums.
	logic [15:0] range_reg;
	logic        mask_reg;
	logic        byte_reg;
	logic [63:0] err_acc;
	logic [31:0] wt_acc;

	psnr_result_t psnr_queue[$];
	int mismatches;
	int images_sent;
	int samples_sent;
	int results_seen;
	int empty_seen;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold_left;
	int cycle_count;

	masked_psnr_accumulator_core #(.MAX_SAMPLES_LOG2(MAX_LOG2)) dut (.*);

	// Clock generation.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Run-length watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL masked_psnr_accumulator_core");
			$finish;
		end
	end

	// log2 of a nonzero integer in Q16, fraction by repeated squaring.
	function automatic logic [63:0] log2_fix(input logic [63:0] x);
		int n;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] frac;
		n = 0;
		t = x;
		frac = '0;
		while (t > 1) begin
			t = t >> 1;
			n++;
		end
		if (n >= 31) begin
			y = x >> (n - 31);
		end else begin
			y = x << (31 - n);
		end
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac[0] = 1'b1;
				y = y >> 1;
			end
		end
		return (64'(n) << 16) | frac;
	endfunction

	// Q32 dB value to saturated Q8.8, rounding half away from zero.
	function automatic logic [15:0] db_to_q8_8(input longint v);
		logic [63:0] mag;
		logic [63:0] r;
		if (v >= 0) begin
			r = (64'(v) + (64'd1 << 23)) >> 24;
			if (r > 32767) r = 32767;
			return r[15:0];
		end
		mag = -64'(v);
		r = (mag + (64'd1 << 23)) >> 24;
		if (r > 32768) r = 32768;
		return 16'(-r);
	endfunction

	function automatic logic [15:0] psnr_from_sums();
		longint a;
		longint b;
		longint l;
		if (range_reg == 0) return 16'h8000;
		if (err_acc == 0) begin
			a = DB_CAP;
		end else begin
			l = longint'(log2_fix(64'(wt_acc))) + (longint'(30) <<< 16)
				- longint'(log2_fix(err_acc));
			a = l * K_DB;
			if (a > DB_CAP) a = DB_CAP;
		end
		b = (longint'(log2_fix(64'(range_reg))) - (longint'(8) <<< 16)) * (2 * K_DB);
		return db_to_q8_8(a + b);
	endfunction

	// Accumulate one accepted sample and queue a result on the last one.
	task automatic accumulate_sample(input logic [15:0] p, input logic [15:0] t,
			input logic [7:0] w, input logic l);
		longint targ;
		longint diff;
		logic [63:0] wt;
		logic [63:0] contrib;
		psnr_result_t r;
		wt = mask_reg ? 64'(w) : 64'd1;
		if (byte_reg) begin
			targ = longint'((64'(t[7:0]) * 32768 + 127) / 255);
		end else begin
			targ = longint'(t);
		end
		diff = longint'(p) - targ;
		contrib = 64'(diff * diff) * wt;
		if (contrib > ERR_CAP - err_acc) begin
			err_acc = ERR_CAP;
		end else begin
			err_acc = err_acc + contrib;
		end
		if (wt > 64'hFFFF_FFFF - 64'(wt_acc)) begin
			wt_acc = 32'hFFFF_FFFF;
		end else begin
			wt_acc = wt_acc + wt[31:0];
		end
		if (l) begin
			if (wt_acc == 0) begin
				r.psnr = '0;
				r.empty = 1'b1;
			end else begin
				r.psnr = psnr_from_sums();
				r.empty = 1'b0;
			end
			psnr_queue = {psnr_queue, r};
			err_acc = '0;
			wt_acc = '0;
			images_sent++;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at %0t: %s got 0x%04h expected 0x%04h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Result checker: every output transfer against the oldest expectation.
	always @(posedge clk) begin
		psnr_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (psnr_queue.size() == 0) begin
				report_mismatch("unexpected result psnr_db", psnr_db, 16'h0);
			end else begin
				e = psnr_queue.pop_front();
				if (e.empty) empty_seen++;
				if (psnr_db !== e.psnr) report_mismatch("psnr_db", psnr_db, e.psnr);
				if (status !== e.empty) report_mismatch("status", 16'(status), 16'(e.empty));
			end
		end
	end

	// Receiver: random stalls plus an optional long hold-off.
	always @(posedge clk) begin
		if (recv_hold_left > 0) begin
			out_ready <= 1'b0;
			recv_hold_left <= recv_hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one sample and wait for its transfer; valid stays high afterwards.
	task automatic send_sample(input logic [15:0] p, input logic [15:0] t,
			input logic [7:0] w, input logic l);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pred_sample <= p;
		target_sample <= t;
		mask_weight <= w;
		last_sample <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		samples_sent++;
		accumulate_sample(p, t, w, l);
	endtask

	// Stop offering, let every result arrive and the log unit go quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (psnr_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the block must be idle.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RANGE: range_reg = val;
			REG_MASK:  mask_reg = val[0];
			REG_BYTE:  byte_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] rng, input logic msk, input logic byt);
		write_reg(REG_RANGE, rng);
		write_reg(REG_MASK, {15'h7FFF, msk});
		write_reg(REG_BYTE, {15'h0, byt});
	endtask

	// Plain mean with default range: zero error, full-scale and oversized samples.
	task automatic test_plain_extremes();
		send_sample(16'd1000, 16'd1000, 8'd0, 1'b1);
		send_sample(16'd0, 16'd32768, 8'd17, 1'b0);
		send_sample(16'd32768, 16'd0, 8'd0, 1'b1);
		send_sample(16'hFFFF, 16'h0000, 8'hFF, 1'b0);
		send_sample(16'h0000, 16'hFFFF, 8'h00, 1'b1);
		send_sample(16'h5555, 16'hAAAA, 8'h55, 1'b1);
		drain();
	endtask

	// Masked mode: empty mask, zero weights mixed in, and full weights.
	task automatic test_masked();
		set_config(16'd256, 1'b1, 1'b0);
		send_sample(16'd100, 16'd9000, 8'd0, 1'b0);
		send_sample(16'd200, 16'd30000, 8'd0, 1'b1);
		send_sample(16'd4000, 16'd4100, 8'd0, 1'b0);
		send_sample(16'd4000, 16'd4100, 8'd255, 1'b1);
		send_sample(16'hFFFF, 16'd0, 8'd255, 1'b1);
		send_sample(16'd7, 16'd7, 8'hAA, 1'b1);
		drain();
	endtask

	// Byte targets, including targets wider than a byte.
	task automatic test_byte_mode();
		set_config(16'd256, 1'b0, 1'b1);
		send_sample(16'd32768, 16'd255, 8'd3, 1'b1);
		send_sample(16'd0, 16'hFF00, 8'd3, 1'b1);
		send_sample(16'd12345, 16'h1281, 8'd3, 1'b0);
		send_sample(16'd128, 16'd1, 8'd3, 1'b1);
		drain();
	endtask

	// Range extremes: zero, smallest, largest, and an unused register index.
	task automatic test_range_extremes();
		set_config(16'd0, 1'b0, 1'b0);
		send_sample(16'd10, 16'd20000, 8'd1, 1'b1);
		drain();
		write_reg(REG_RANGE, 16'd1);
		send_sample(16'd10, 16'd20000, 8'd1, 1'b1);
		send_sample(16'd10, 16'd10, 8'd1, 1'b1);
		drain();
		write_reg(REG_RANGE, 16'hFFFF);
		write_reg(REG_UNUSED, 16'h1234);
		send_sample(16'd10, 16'd11, 8'd1, 1'b1);
		send_sample(16'd10, 16'd10, 8'd1, 1'b1);
		drain();
	endtask

	task automatic random_config();
		logic [15:0] rng;
		case ($urandom_range(5))
			0: rng = 16'd0;
			1: rng = 16'd1;
			2: rng = 16'hFFFF;
			3: rng = 16'd256;
			default: rng = 16'($urandom);
		endcase
		set_config(rng, 1'($urandom), 1'($urandom));
	endtask

	// One image of random samples; pred usually lands near the target.
	task automatic send_random_image(input int len);
		logic [15:0] p;
		logic [15:0] t;
		logic [7:0] w;
		for (int i = 0; i < len; i++) begin
			t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
			case ($urandom_range(3))
				0: p = 16'($urandom);
				1: p = t;
				default: p = t + 16'($urandom_range(64)) - 16'd32;
			endcase
			w = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
			send_sample(p, t, w, i == len - 1);
		end
	endtask

	task automatic test_random_phase(input int n_items, input int s_pct, input int r_pct);
		int sent;
		int len;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) == 0) begin
				drain();
				random_config();
			end
			len = ($urandom_range(15) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
			send_random_image(len);
			sent += len;
		end
		drain();
	endtask

	// Receiver holds off for a long stretch while images keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_left = 600;
		for (int i = 0; i < 6; i++) send_random_image($urandom_range(1, 5));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pred_sample = '0;
		target_sample = '0;
		mask_weight = '0;
		last_sample = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RANGE;
		cfg_data = '0;
		range_reg = 16'd256;
		mask_reg = 1'b0;
		byte_reg = 1'b0;
		err_acc = '0;
		wt_acc = '0;
		mismatches = 0;
		images_sent = 0;
		samples_sent = 0;
		results_seen = 0;
		empty_seen = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_left = 0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_extremes();
		test_masked();
		test_byte_mode();
		test_range_extremes();
		test_random_phase(230, 7, 53);
		test_random_phase(230, 53, 7);
		test_random_phase(230, 0, 0);
		test_backpressure();

		$display("covered %0d samples in %0d images, %0d results checked (%0d empty mask)",
			samples_sent, images_sent, results_seen, empty_seen);
		$display("modes: plain, masked, byte target, range 0/1/max, long output stall");
		if (mismatches == 0 && psnr_queue.size() == 0) begin
			$display("PASS masked_psnr_accumulator_core");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, psnr_queue.size());
			$display("FAIL masked_psnr_accumulator_core");
		end
		$finish;
	end

endmodule
